/* design/ttim_pkg.sv */
`timescale 1ns / 1ps
package ttim_pkg;

  localparam int IDX_W      = 32;
  localparam int EXT_W      = 16;
  localparam int NUM_AXES   = 6;
  localparam int AX_W       = 3;
  localparam int RANK_W     = 3;
  localparam int PERM_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int ST_W       = 2;
  localparam int RECIP_W    = IDX_W + 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int REM_W      = EXT_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_RANK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXT0 = 3'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_PERM = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;

  localparam logic [RANK_W-1:0] RANK_RST = 3'd1;
  localparam logic [PERM_W-1:0] PERM_RST = 18'd181896;
  localparam logic [EXT_W-1:0]  EXT_RST  = 16'd1;

  // Per-slot tables; slot k handles output axis rank-1-k (innermost first).
  typedef struct packed {
    logic                                  perm_ok;
    logic [CNT_W-1:0]                      count;
    logic [NUM_AXES-1:0]                   used;
    logic [NUM_AXES-1:0][EXT_W-1:0]        div;
    logic [NUM_AXES-1:0][RECIP_W-1:0]      recip;
    logic [NUM_AXES-1:0][IDX_W-1:0]        istr;
  } map_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] rest;
    logic [IDX_W-1:0] acc;
    logic [EXT_W-1:0] coord;
    logic [ST_W-1:0]  status;
  } beat_t;

endpackage

/* design/ttim_intf.sv */
`timescale 1ns / 1ps
interface ttim_in_if;
  import ttim_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_index;
  modport source (output valid, output out_index, input ready);
  modport sink (input valid, input out_index, output ready);
endinterface

interface ttim_out_if;
  import ttim_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] in_index;
  logic [ST_W-1:0]  status;
  modport source (output valid, output in_index, output status, input ready);
  modport sink (input valid, input in_index, input status, output ready);
endinterface

/* design/ttim_setup.sv */
`timescale 1ns / 1ps
module ttim_setup #(
  parameter int MAX_RANK = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ttim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ttim_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ttim_pkg::map_cfg_t            map_cfg,
  output logic                          busy
);
  import ttim_pkg::*;

  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(RECIP_W);
  localparam logic [STEP_W-1:0] SETUP_LAST = STEP_W'(RECIP_W + 1);
  localparam logic [CNT_W-1:0]  CAP = {1'b1, {IDX_W{1'b0}}};
  localparam int SAT_W = CNT_W + EXT_W;

  logic [RANK_W-1:0] rank_r;
  logic [PERM_W-1:0] perm_r;
  logic [EXT_W-1:0]  ext_r [NUM_AXES];
  logic              busy_r;
  logic [STEP_W-1:0] step_r;

  logic [EXT_W-1:0]   sd_r  [NUM_AXES];
  logic [AX_W-1:0]    sa_r  [NUM_AXES];
  logic [NUM_AXES-1:0] used_r;
  logic               ok_r;
  logic [EXT_W-1:0]   rem_r [NUM_AXES];
  logic [RECIP_W-1:0] q_r   [NUM_AXES];
  logic [IDX_W-1:0]   is_r  [NUM_AXES];
  logic [IDX_W-1:0]   sis_r [NUM_AXES];
  logic [IDX_W-1:0]   run_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [RANK_W-1:0]  r_use;
  logic [AX_W-1:0]    ax   [NUM_AXES];
  logic [AX_W-1:0]    sa   [NUM_AXES];
  logic [EXT_W-1:0]   dv   [NUM_AXES];
  logic [NUM_AXES-1:0] used;
  logic               perm_ok;
  logic [7:0]         seen;
  logic [AX_W-1:0]    pos;
  logic [EXT_W-1:0]   rem_nxt [NUM_AXES];
  logic [RECIP_W-1:0] q_nxt   [NUM_AXES];
  logic [REM_W-1:0]   trial;
  logic               stride_step;
  logic [AX_W-1:0]    j_ax;
  logic [AX_W-1:0]    k_sl;
  logic [IDX_W+EXT_W-1:0] run_prod;
  logic [SAT_W-1:0]   cnt_prod;
  logic [IDX_W-1:0]   run_nxt;
  logic [CNT_W-1:0]   cnt_nxt;

  // Rank decode and permutation check.
  always_comb begin
    seen    = '0;
    perm_ok = 1'b1;
    pos     = '0;
    if (rank_r == '0) begin
      r_use = RANK_W'(1);
    end else if (rank_r > RANK_W'(MAX_RANK)) begin
      r_use = RANK_W'(MAX_RANK);
    end else begin
      r_use = rank_r;
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      ax[i] = perm_r[i*AX_W +: AX_W];
      if (AX_W'(i) < r_use) begin
        if (ax[i] >= r_use || seen[ax[i]]) begin
          perm_ok = 1'b0;
        end
        seen[ax[i]] = 1'b1;
      end
    end
    for (int k = 0; k < NUM_AXES; k++) begin
      used[k] = AX_W'(k) < r_use;
      sa[k]   = '0;
      dv[k]   = EXT_RST;
      if (used[k]) begin
        pos   = r_use - AX_W'(k) - AX_W'(1);
        sa[k] = ax[pos];
        if (sa[k] < AX_W'(NUM_AXES)) begin
          dv[k] = ext_r[sa[k]];
        end
      end
    end
  end

  // One quotient bit of 2^IDX_W / divisor per step, for every slot at once.
  always_comb begin
    trial = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      trial = {rem_r[k], step_r == STEP_W'(1)};
      if (trial >= {1'b0, sd_r[k]}) begin
        rem_nxt[k] = EXT_W'(trial - {1'b0, sd_r[k]});
        q_nxt[k]   = {q_r[k][RECIP_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[EXT_W-1:0];
        q_nxt[k]   = {q_r[k][RECIP_W-2:0], 1'b0};
      end
    end
  end

  // Stride and element-count chains, one axis per step.
  always_comb begin
    stride_step = step_r >= STEP_W'(1) && step_r <= STEP_W'(NUM_AXES)
                  && step_r[AX_W-1:0] <= r_use;
    j_ax     = r_use - step_r[AX_W-1:0];
    k_sl     = step_r[AX_W-1:0] - AX_W'(1);
    run_prod = (IDX_W+EXT_W)'(run_r) * (IDX_W+EXT_W)'(ext_r[j_ax]);
    run_nxt  = run_prod[IDX_W-1:0];
    cnt_prod = SAT_W'(cnt_r) * SAT_W'(sd_r[k_sl]);
    cnt_nxt  = (cnt_prod > SAT_W'(CAP)) ? CAP : cnt_prod[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_RST;
      perm_r <= PERM_RST;
      for (int i = 0; i < NUM_AXES; i++) begin
        ext_r[i] <= EXT_RST;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANK: rank_r <= cfg_wdata[RANK_W-1:0];
        REG_PERM: perm_r <= cfg_wdata[PERM_W-1:0];
        default:  ext_r[cfg_index - REG_EXT0] <= cfg_wdata[EXT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (cfg_we) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == SETUP_LAST) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !cfg_we) begin
      if (step_r == '0) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          sd_r[k]  <= dv[k];
          sa_r[k]  <= sa[k];
          rem_r[k] <= '0;
          q_r[k]   <= '0;
        end
        used_r <= used;
        ok_r   <= perm_ok;
        run_r  <= IDX_W'(1);
        cnt_r  <= CNT_W'(1);
      end else begin
        if (step_r <= DIV_STEPS) begin
          for (int k = 0; k < NUM_AXES; k++) begin
            rem_r[k] <= rem_nxt[k];
            q_r[k]   <= q_nxt[k];
          end
        end
        if (stride_step) begin
          is_r[j_ax] <= run_r;
          run_r      <= run_nxt;
          cnt_r      <= cnt_nxt;
        end
        if (step_r == SETUP_LAST) begin
          for (int k = 0; k < NUM_AXES; k++) begin
            if (used_r[k] && sa_r[k] < AX_W'(NUM_AXES)) begin
              sis_r[k] <= is_r[sa_r[k]];
            end else begin
              sis_r[k] <= '0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    map_cfg.perm_ok = ok_r;
    map_cfg.count   = cnt_r;
    map_cfg.used    = used_r;
    for (int k = 0; k < NUM_AXES; k++) begin
      map_cfg.div[k]   = sd_r[k];
      map_cfg.recip[k] = q_r[k];
      map_cfg.istr[k]  = sis_r[k];
    end
  end

  assign busy = busy_r;

endmodule

/* design/ttim_slot.sv */
`timescale 1ns / 1ps
module ttim_slot (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  input  ttim_pkg::beat_t              up_beat,
  output logic                         up_en,
  input  logic                         down_en,
  output logic                         down_valid,
  output ttim_pkg::beat_t              down_beat,
  input  logic [ttim_pkg::EXT_W-1:0]   div,
  input  logic [ttim_pkg::RECIP_W-1:0] recip,
  input  logic [ttim_pkg::IDX_W-1:0]   istr_prev,
  input  logic                         used
);
  import ttim_pkg::*;

  localparam int PROD_W = IDX_W + RECIP_W;
  localparam int MAC_W  = IDX_W + EXT_W;

  logic             a_v_r, b_v_r, c_v_r;
  beat_t            a_beat_r, b_beat_r, c_beat_r;
  logic [IDX_W-1:0] a_qe_r, b_qe_r;
  logic [REM_W-1:0] b_rem_r;

  logic             a_en, b_en, c_en;
  logic [PROD_W-1:0] prod_a;
  logic [MAC_W-1:0] mac_a, qd_b;
  logic [IDX_W-1:0] diff_b;
  beat_t            a_beat_nxt, c_beat_nxt;
  logic             fix_c;
  logic [REM_W-1:0] sub_c;

  assign c_en  = !c_v_r || down_en;
  assign b_en  = !b_v_r || c_en;
  assign a_en  = !a_v_r || b_en;
  assign up_en = a_en;

  // Stage A: quotient estimate by reciprocal, and the previous slot's term.
  always_comb begin
    prod_a         = PROD_W'(up_beat.rest) * PROD_W'(recip);
    mac_a          = MAC_W'(up_beat.coord) * MAC_W'(istr_prev);
    a_beat_nxt     = up_beat;
    a_beat_nxt.acc = up_beat.acc + mac_a[IDX_W-1:0];
    a_beat_nxt.coord = '0;
  end

  // Stage B: remainder of the estimate, below twice the divisor.
  always_comb begin
    qd_b   = MAC_W'(a_qe_r) * MAC_W'(div);
    diff_b = a_beat_r.rest - qd_b[IDX_W-1:0];
  end

  // Stage C: the estimate may be one short; fix it up.
  always_comb begin
    fix_c      = b_rem_r >= {1'b0, div};
    sub_c      = b_rem_r - {1'b0, div};
    c_beat_nxt = b_beat_r;
    if (used) begin
      if (fix_c) begin
        c_beat_nxt.coord = sub_c[EXT_W-1:0];
        c_beat_nxt.rest  = b_qe_r + IDX_W'(1);
      end else begin
        c_beat_nxt.coord = b_rem_r[EXT_W-1:0];
        c_beat_nxt.rest  = b_qe_r;
      end
    end else begin
      c_beat_nxt.coord = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_en) a_v_r <= up_valid;
      if (b_en) b_v_r <= a_v_r;
      if (c_en) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_beat_r <= a_beat_nxt;
      a_qe_r   <= prod_a[IDX_W +: IDX_W];
    end
    if (b_en) begin
      b_beat_r <= a_beat_r;
      b_qe_r   <= a_qe_r;
      b_rem_r  <= diff_b[REM_W-1:0];
    end
    if (c_en) begin
      c_beat_r <= c_beat_nxt;
    end
  end

  assign down_valid = c_v_r;
  assign down_beat  = c_beat_r;

endmodule

/* design/tensor_transpose_index_map.sv */
`timescale 1ns / 1ps
// Each axis is a three-stage reciprocal divider, between an entry and an output register.
// Throughput: one index per cycle while out_ch.ready is high and setup is not busy.
// After reset, and again after every configuration write, the stride and
// reciprocal tables are rebuilt with in_ch.ready held low.
// Reset is synchronous, active low, and clears every valid bit.
module tensor_transpose_index_map #(
  parameter int MAX_RANK = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ttim_in_if.sink                         in_ch,
  ttim_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ttim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttim_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ttim_pkg::*;

  localparam int MAC_W = IDX_W + EXT_W;

  map_cfg_t         map_cfg;
  logic             busy;

  logic             e_v_r;
  beat_t            e_beat_r;
  beat_t            e_beat_nxt;
  logic             e_en;

  logic [MAX_RANK:0] chain_v;
  logic [MAX_RANK:0] chain_en;
  beat_t            chain_beat [MAX_RANK+1];

  logic             o_v_r;
  logic [IDX_W-1:0] o_index_r;
  logic [ST_W-1:0]  o_status_r;
  logic             o_en;
  logic [MAC_W-1:0] mac_o;
  beat_t            last_beat;

  ttim_setup #(.MAX_RANK(MAX_RANK)) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .map_cfg   (map_cfg),
    .busy      (busy)
  );

  // Entry stage: range and permutation checks.
  assign e_en        = !e_v_r || chain_en[0];
  assign in_ch.ready = e_en && !busy;

  always_comb begin
    e_beat_nxt.rest  = in_ch.out_index;
    e_beat_nxt.acc   = '0;
    e_beat_nxt.coord = '0;
    if (!map_cfg.perm_ok) begin
      e_beat_nxt.status = ST_BAD_PERM;
    end else if ({1'b0, in_ch.out_index} >= map_cfg.count) begin
      e_beat_nxt.status = ST_RANGE;
    end else begin
      e_beat_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (e_en) begin
      e_v_r <= in_ch.valid && in_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (e_en) begin
      e_beat_r <= e_beat_nxt;
    end
  end

  assign chain_v[0]    = e_v_r;
  assign chain_beat[0] = e_beat_r;

  for (genvar k = 0; k < MAX_RANK; k++) begin : g_slot
    logic [IDX_W-1:0] istr_prev;
    if (k == 0) begin : g_first
      assign istr_prev = '0;
    end else begin : g_rest
      assign istr_prev = map_cfg.istr[k-1];
    end

    ttim_slot u_slot (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (chain_v[k]),
      .up_beat    (chain_beat[k]),
      .up_en      (chain_en[k]),
      .down_en    (chain_en[k+1]),
      .down_valid (chain_v[k+1]),
      .down_beat  (chain_beat[k+1]),
      .div        (map_cfg.div[k]),
      .recip      (map_cfg.recip[k]),
      .istr_prev  (istr_prev),
      .used       (map_cfg.used[k])
    );
  end

  // Output register: last axis term, error results forced to zero.
  assign o_en               = !o_v_r || out_ch.ready;
  assign chain_en[MAX_RANK] = o_en;
  assign last_beat          = chain_beat[MAX_RANK];
  assign mac_o = MAC_W'(last_beat.coord) * MAC_W'(map_cfg.istr[MAX_RANK-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_en) begin
      o_v_r <= chain_v[MAX_RANK];
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      o_status_r <= last_beat.status;
      if (last_beat.status == ST_OK) begin
        o_index_r <= last_beat.acc + mac_o[IDX_W-1:0];
      end else begin
        o_index_r <= '0;
      end
    end
  end

  assign out_ch.valid    = o_v_r;
  assign out_ch.in_index = o_index_r;
  assign out_ch.status   = o_status_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("input accepted while tables are being rebuilt");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready)
    else $error("input ready right after a configuration write");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> out_ch.in_index == '0)
    else $error("error result carries a nonzero index");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_OK || out_ch.status == ST_BAD_PERM ||
                      out_ch.status == ST_RANGE))
    else $error("undefined status code");

endmodule
